>>> sv/bti_pkg.sv
// Shared constants, command item type and kinds for the bilinear table interpolator.
package bti_pkg;

  localparam int ALT_POINTS  = 6;
  localparam int TEMP_POINTS = 4;
  localparam int FRAC_BITS   = 4;

  localparam int ALT_STEP  = 2000 * (1 << FRAC_BITS);
  localparam int TEMP_STEP = 20 * (1 << FRAC_BITS);
  localparam int TEMP_LOW  = -20 * (1 << FRAC_BITS);
  localparam int ALT_MAX   = ALT_STEP * (ALT_POINTS - 1);
  localparam int TEMP_SPAN = TEMP_STEP * (TEMP_POINTS - 1);

  localparam int GRID_SIZE = ALT_POINTS * TEMP_POINTS;
  localparam int GA_W      = $clog2(GRID_SIZE);

  localparam int ALT_W  = 18;
  localparam int TEMP_W = 11;
  localparam int IDX_W  = 5;
  localparam int VAL_W  = 16;

  localparam int DXA_W  = $clog2(ALT_STEP + 1);
  localparam int DXT_W  = $clog2(TEMP_STEP + 1);
  localparam int PROD_W = VAL_W + DXA_W;

  // reciprocals for exact floor division of any PROD_W-bit product by a step
  localparam int RCP_W      = 32;
  localparam int RCP_K_ALT  = PROD_W + $clog2(ALT_STEP);
  localparam int RCP_K_TEMP = PROD_W + $clog2(TEMP_STEP);
  localparam logic [RCP_W-1:0] RCP_ALT =
    RCP_W'(((longint'(1) << RCP_K_ALT) + longint'(ALT_STEP) - 1) / longint'(ALT_STEP));
  localparam logic [RCP_W-1:0] RCP_TEMP =
    RCP_W'(((longint'(1) << RCP_K_TEMP) + longint'(TEMP_STEP) - 1) / longint'(TEMP_STEP));

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_QUERY,
    CMD_OOR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [GA_W-1:0]    addr;
    logic [VAL_W-1:0]   value;
    logic [DXA_W-1:0]   dx_a;
    logic [DXT_W-1:0]   dx_t;
  } cmd_t;

endpackage

>>> sv/bti_front.sv
// Front end: accept items, range check queries, find the grid cell and offsets.
module bti_front import bti_pkg::*; (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     op,
  input  logic [ALT_W-1:0]         altitude,
  input  logic signed [TEMP_W-1:0] temperature,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic [VAL_W-1:0]         entry_value,
  input  logic                     q_space,
  output logic                     push,
  output cmd_t                     cmd
);

  logic keep;

  assign in_ready = q_space;
  assign push     = in_valid && q_space && keep;

  always_comb begin
    int  alt_i;
    int  toff;
    int  ai;
    int  ti;
    int  abase;
    int  tbase;
    logic in_rng;
    alt_i  = int'(altitude);
    toff   = int'(temperature) - TEMP_LOW;
    in_rng = (alt_i <= ALT_MAX) && (toff >= 0) && (toff <= TEMP_SPAN);
    ai     = 0;
    abase  = 0;
    ti     = 0;
    tbase  = 0;
    // pick the cell below an inner breakpoint
    for (int k = 1; k <= ALT_POINTS - 2; k++) begin
      if (alt_i > k * ALT_STEP) begin
        ai    = k;
        abase = k * ALT_STEP;
      end
    end
    for (int k = 1; k <= TEMP_POINTS - 2; k++) begin
      if (toff > k * TEMP_STEP) begin
        ti    = k;
        tbase = k * TEMP_STEP;
      end
    end
    keep       = !op || (int'(entry_index) < GRID_SIZE);
    cmd.value  = entry_value;
    cmd.dx_a   = DXA_W'(alt_i - abase);
    cmd.dx_t   = DXT_W'(toff - tbase);
    if (op) begin
      cmd.kind = CMD_WRITE;
      cmd.addr = GA_W'(entry_index);
    end else begin
      cmd.kind = in_rng ? CMD_QUERY : CMD_OOR;
      cmd.addr = GA_W'(ai * TEMP_POINTS + ti);
    end
  end

endmodule

>>> sv/bti_queue.sv
// Two-entry command queue between front end and back end.
module bti_queue import bti_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic space,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  localparam int DEPTH = 2;

  cmd_t       slots [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign space     = (count != 2'(DEPTH));
  assign pop_valid = (count != 2'd0);
  assign pop_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/bti_back.sv
// Back end: grid memory, corner reads, multiply and reciprocal divide, result register.
module bti_back import bti_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop,
  input  cmd_t             pop_cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] climb_rate,
  output logic             in_range
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_MUL,
    S_DIV,
    S_ADD
  } state_t;

  state_t             state;
  cmd_t               cur;
  logic [VAL_W-1:0]   grid [GRID_SIZE];
  logic [VAL_W-1:0]   rd_data;
  logic [GA_W-1:0]    rd_addr;
  logic               mem_we;
  logic [2:0]         rcnt;
  logic [VAL_W-1:0]   v [4];
  logic [1:0]         lsel;
  logic [VAL_W-1:0]   ly1;
  logic [VAL_W-1:0]   ly2;
  logic [VAL_W-1:0]   lo;
  logic [PROD_W-1:0]  rem;
  logic [VAL_W-1:0]   quo;
  logic               neg;

  logic [VAL_W:0]          diff;
  logic [VAL_W-1:0]        mag;
  logic [DXA_W-1:0]        dx_sel;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W+RCP_W-1:0] qprod;
  logic [VAL_W-1:0]        qval;
  logic [VAL_W-1:0]        lin_res;

  assign pop    = (state == S_IDLE) && pop_valid && !out_valid;
  assign mem_we = (state == S_START) && (cur.kind == CMD_WRITE);

  always_comb begin
    case (rcnt[1:0])
      2'd0:    rd_addr = cur.addr;
      2'd1:    rd_addr = cur.addr + GA_W'(1);
      2'd2:    rd_addr = cur.addr + GA_W'(TEMP_POINTS);
      default: rd_addr = cur.addr + GA_W'(TEMP_POINTS + 1);
    endcase
  end

  assign diff    = {1'b0, ly2} - {1'b0, ly1};
  assign mag     = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
  assign dx_sel  = (lsel == 2'd2) ? cur.dx_a : DXA_W'(cur.dx_t);
  assign prod    = mag * dx_sel;
  assign qprod   = rem * ((lsel == 2'd2) ? RCP_ALT : RCP_TEMP);
  assign qval    = (lsel == 2'd2) ? qprod[RCP_K_ALT +: VAL_W] : qprod[RCP_K_TEMP +: VAL_W];
  assign lin_res = neg ? (ly1 - quo) : (ly1 + quo);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid[cur.addr] <= cur.value;
    end
    rd_data <= grid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            cur   <= pop_cmd;
            state <= S_START;
          end
        end
        S_START: begin
          rcnt <= 3'd0;
          case (cur.kind)
            CMD_QUERY: state <= S_READ;
            CMD_OOR: begin
              climb_rate <= '0;
              in_range   <= 1'b0;
              out_valid  <= 1'b1;
              state      <= S_IDLE;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_READ: begin
          if (rcnt != 3'd0) begin
            v[2'(rcnt - 3'd1)] <= rd_data;
          end
          if (rcnt == 3'd4) begin
            ly1   <= v[0];
            ly2   <= v[1];
            lsel  <= 2'd0;
            state <= S_MUL;
          end else begin
            rcnt <= rcnt + 3'd1;
          end
        end
        S_MUL: begin
          rem   <= prod;
          neg   <= diff[VAL_W];
          state <= S_DIV;
        end
        S_DIV: begin
          quo   <= qval;
          state <= S_ADD;
        end
        S_ADD: begin
          case (lsel)
            2'd0: begin
              lo    <= lin_res;
              ly1   <= v[2];
              ly2   <= v[3];
              lsel  <= 2'd1;
              state <= S_MUL;
            end
            2'd1: begin
              ly1   <= lo;
              ly2   <= lin_res;
              lsel  <= 2'd2;
              state <= S_MUL;
            end
            default: begin
              climb_rate <= lin_res;
              in_range   <= 1'b1;
              out_valid  <= 1'b1;
              state      <= S_IDLE;
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/bilinear_table_interpolator.sv
// Bilinear table interpolator top level: front end, command queue, back end.
// A query goes through the queue, a start state, the corner reads through the single grid
// memory port, then three linear steps (multiply, reciprocal divide, add).
// The back end takes a new item only in its idle state with out_valid clear, so it finishes
// one item before it takes the next. Input is taken whenever the two-entry queue has room;
// rst is synchronous and clears control state only, grid entries hold garbage until written.
module bilinear_table_interpolator import bti_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     op,
  input  logic [ALT_W-1:0]         altitude,
  input  logic signed [TEMP_W-1:0] temperature,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic [VAL_W-1:0]         entry_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [VAL_W-1:0]         climb_rate,
  output logic                     in_range
);

  logic q_space;
  logic push;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop;
  cmd_t pop_cmd;

  bti_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .altitude    (altitude),
    .temperature (temperature),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .q_space     (q_space),
    .push        (push),
    .cmd         (push_cmd)
  );

  bti_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .space     (q_space),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_cmd   (pop_cmd)
  );

  bti_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .climb_rate (climb_rate),
    .in_range   (in_range)
  );

endmodule
